// ----- hw/rtl/plc_pkg.sv -----
// ----------------------------------------------------------------------------
// plc_pkg
// Shared types and constants for the pointer look conditioner: field widths,
// limits, result status codes, sequencer states and control structs.
// ----------------------------------------------------------------------------
package plc_pkg;

  // fixed field widths
  localparam int PTR_W       = 17;
  localparam int SENS_W      = 16;
  localparam int YAW_OUT_W   = 25;
  localparam int PITCH_OUT_W = 24;
  localparam int SMOOTH_W    = 25;

  // default angle precision
  localparam int ANGLE_FRAC_BITS_DEF = 16;

  // limits in sixteenths of a pixel
  localparam int JUMP_LIMIT  = 8000;
  localparam int DELTA_LIMIT = 3200;

  // smoothing weight 0.3 in Q0.16
  localparam int SMOOTH_WEIGHT  = 19661;
  localparam int SENS_FRAC_BITS = 12;

  localparam logic [SENS_W-1:0] SENS_RST = 16'd410;

  // yaw wrap sequence length
  localparam int WRAP_STEPS = 5;
  localparam int STEP_W     = 3;

  typedef enum logic [1:0] {
    ST_UPDATED = 2'd0,
    ST_SKIPPED = 2'd1,
    ST_INIT    = 2'd2,
    ST_JUMP    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASSIFY,
    S_MUL_SMOOTH,
    S_SMOOTH_UPD,
    S_MUL_SENS,
    S_ACCUM,
    S_WRAP,
    S_DONE
  } state_t;

  // datapath commands
  typedef struct packed {
    logic              capture;
    logic              classify;
    logic              mul_smooth;
    logic              smooth_upd;
    logic              mul_sens;
    logic              accum;
    logic              wrap;
    logic [STEP_W-1:0] wrap_step;
    logic              wrap_last;
    logic              out_load;
  } cmd_t;

  // sample classification back to the controller
  typedef struct packed {
    logic skip;
    logic init;
    logic jump;
  } sample_flags_t;

endpackage

// ----- hw/rtl/plc_ctrl.sv -----
// ----------------------------------------------------------------------------
// plc_ctrl
// Sequencer: walks one item through classify, smoothing, scaling and yaw
// wrap, and owns the input stall and the result valid.
// ----------------------------------------------------------------------------
module plc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  plc_pkg::sample_flags_t flags,
  output plc_pkg::cmd_t         cmd
);

  plc_pkg::state_t              state_r, state_nxt;
  logic [plc_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign in_stall  = (state_r != plc_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plc_pkg::S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.wrap_step = step_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      plc_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = plc_pkg::S_CLASSIFY;
        end
      end
      plc_pkg::S_CLASSIFY: begin
        cmd.classify = 1'b1;
        if (flags.skip || flags.init || flags.jump) begin
          state_nxt = plc_pkg::S_DONE;
        end else begin
          state_nxt = plc_pkg::S_MUL_SMOOTH;
        end
      end
      plc_pkg::S_MUL_SMOOTH: begin
        cmd.mul_smooth = 1'b1;
        state_nxt      = plc_pkg::S_SMOOTH_UPD;
      end
      plc_pkg::S_SMOOTH_UPD: begin
        cmd.smooth_upd = 1'b1;
        state_nxt      = plc_pkg::S_MUL_SENS;
      end
      plc_pkg::S_MUL_SENS: begin
        cmd.mul_sens = 1'b1;
        state_nxt    = plc_pkg::S_ACCUM;
      end
      plc_pkg::S_ACCUM: begin
        cmd.accum = 1'b1;
        step_nxt  = '0;
        state_nxt = plc_pkg::S_WRAP;
      end
      plc_pkg::S_WRAP: begin
        cmd.wrap = 1'b1;
        if (step_r == plc_pkg::STEP_W'(plc_pkg::WRAP_STEPS - 1)) begin
          cmd.wrap_last = 1'b1;
          state_nxt     = plc_pkg::S_DONE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      plc_pkg::S_DONE: begin
        // wait for the result register to be free
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = plc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = plc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/plc_dp.sv -----
// ----------------------------------------------------------------------------
// plc_dp
// Datapath: position history, delta conditioning, smoothing filter, angle
// accumulators with pitch clamp and stepwise yaw wrap, result register.
// ----------------------------------------------------------------------------
module plc_dp #(
  parameter int ANGLE_FRAC_BITS = plc_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  plc_pkg::cmd_t                       cmd,
  output plc_pkg::sample_flags_t              flags,
  input  logic signed [plc_pkg::PTR_W-1:0]    in_pointer_x,
  input  logic signed [plc_pkg::PTR_W-1:0]    in_pointer_y,
  input  logic                                in_in_viewport,
  input  logic                                in_ui_wants_pointer,
  input  logic                                cfg_we,
  input  logic [plc_pkg::SENS_W-1:0]          cfg_look_sensitivity,
  output logic [1:0]                          out_status,
  output logic [plc_pkg::YAW_OUT_W-1:0]       out_yaw_angle,
  output logic signed [plc_pkg::PITCH_OUT_W-1:0] out_pitch_angle,
  output logic signed [plc_pkg::SMOOTH_W-1:0] out_smooth_dx,
  output logic signed [plc_pkg::SMOOTH_W-1:0] out_smooth_dy
);

  localparam int A       = ANGLE_FRAC_BITS;
  localparam int PW      = plc_pkg::PTR_W;
  localparam int DW      = PW + 1;                 // position difference
  localparam int CW      = 13;                     // clamped delta, +-3200
  localparam int SW      = plc_pkg::SMOOTH_W;
  localparam int MW      = 42;                     // product width
  localparam int YAW_W   = A + 9;                  // [0, 360) degrees
  localparam int PITCH_W = A + 8;                  // +-89 degrees
  localparam int VW      = A + 15;                 // yaw before wrap
  localparam int SH      = 16 + plc_pkg::SENS_FRAC_BITS - A;

  localparam logic signed [DW-1:0] JLIM_P = DW'(plc_pkg::JUMP_LIMIT);
  localparam logic signed [DW-1:0] JLIM_N = -JLIM_P;
  localparam logic signed [DW-1:0] DLIM_P = DW'(plc_pkg::DELTA_LIMIT);
  localparam logic signed [DW-1:0] DLIM_N = -DLIM_P;
  localparam logic signed [CW-1:0] DZ_P   = CW'(1);
  localparam logic signed [CW-1:0] DZ_N   = -DZ_P;

  localparam logic signed [15:0]   WEIGHT = 16'(plc_pkg::SMOOTH_WEIGHT);
  localparam logic signed [MW-1:0] RND16  = MW'(longint'(1) << 15);
  localparam logic signed [MW-1:0] RNDSH  = MW'(longint'(1) << (SH - 1));

  localparam logic signed [VW-1:0] MOD1   = VW'(longint'(360) << A);
  localparam logic signed [VW-1:0] MOD2   = VW'(longint'(360) << (A + 1));
  localparam logic signed [VW-1:0] MOD4   = VW'(longint'(360) << (A + 2));
  localparam logic signed [VW-1:0] MOD8   = VW'(longint'(360) << (A + 3));
  localparam logic signed [VW-1:0] MOD16  = VW'(longint'(360) << (A + 4));
  localparam logic signed [VW-1:0] PLIM_P = VW'(longint'(89) << A);
  localparam logic signed [VW-1:0] PLIM_N = -PLIM_P;

  localparam logic [YAW_W-1:0] YAW_RST = YAW_W'(longint'(225) << A);
  localparam longint PITCH_RST_L =
    ((longint'(-2311087) * (longint'(1) << A)) + longint'(32768)) >>> 16;
  localparam logic signed [PITCH_W-1:0] PITCH_RST = PITCH_W'(PITCH_RST_L);

  // captured item
  logic signed [PW-1:0] px_r, py_r;
  logic                 vp_r, ui_r;

  // state
  logic signed [PW-1:0]    last_x_r, last_y_r;
  logic signed [SW-1:0]    smooth_x_r, smooth_y_r;
  logic [YAW_W-1:0]        yaw_r;
  logic signed [PITCH_W-1:0] pitch_r;
  logic [plc_pkg::SENS_W-1:0] sens_r;

  // working registers
  plc_pkg::status_t        status_r;
  logic signed [SW-1:0]    tx_r, ty_r;
  logic signed [MW-1:0]    prod_x_r, prod_y_r;
  logic signed [VW-1:0]    v_r;

  // result register
  plc_pkg::status_t          out_status_r;
  logic [plc_pkg::YAW_OUT_W-1:0] out_yaw_r;
  logic signed [plc_pkg::PITCH_OUT_W-1:0] out_pitch_r;
  logic signed [SW-1:0]      out_sdx_r, out_sdy_r;

  // classification and delta conditioning
  logic signed [DW-1:0] dx, dy, dx_cl, dy_cl;
  logic signed [CW-1:0] dx_c, dy_c;
  logic                 dead;
  logic signed [SW-1:0] tx_nxt, ty_nxt;
  plc_pkg::status_t     status_nxt;

  always_comb begin
    dx = DW'(px_r) - DW'(last_x_r);
    dy = DW'(py_r) - DW'(last_y_r);

    flags.skip = !vp_r && ui_r;
    flags.init = last_x_r[PW-1] || last_y_r[PW-1];
    flags.jump = (dx > JLIM_P) || (dx < JLIM_N) || (dy > JLIM_P) || (dy < JLIM_N);

    if (dx > DLIM_P) begin
      dx_cl = DLIM_P;
    end else if (dx < DLIM_N) begin
      dx_cl = DLIM_N;
    end else begin
      dx_cl = dx;
    end
    if (dy > DLIM_P) begin
      dy_cl = DLIM_P;
    end else if (dy < DLIM_N) begin
      dy_cl = DLIM_N;
    end else begin
      dy_cl = dy;
    end
    dx_c = dx_cl[CW-1:0];
    dy_c = dy_cl[CW-1:0];

    // squared length of at most 2 means both axes within one sixteenth
    dead = (dx_c >= DZ_N) && (dx_c <= DZ_P) && (dy_c >= DZ_N) && (dy_c <= DZ_P);

    // sixteenths to Q.16 pixels
    tx_nxt = dead ? '0 : {dx_c, 12'b0};
    ty_nxt = dead ? '0 : {dy_c, 12'b0};

    if (flags.skip) begin
      status_nxt = plc_pkg::ST_SKIPPED;
    end else if (flags.init) begin
      status_nxt = plc_pkg::ST_INIT;
    end else if (flags.jump) begin
      status_nxt = plc_pkg::ST_JUMP;
    end else begin
      status_nxt = plc_pkg::ST_UPDATED;
    end
  end

  // smoothing filter
  logic signed [SW:0]   diff_x, diff_y;
  logic signed [MW-1:0] fr_x, fr_y;
  logic signed [SW:0]   sm_x_sum, sm_y_sum;

  always_comb begin
    diff_x   = (SW+1)'(tx_r) - (SW+1)'(smooth_x_r);
    diff_y   = (SW+1)'(ty_r) - (SW+1)'(smooth_y_r);
    fr_x     = (prod_x_r + RND16) >>> 16;
    fr_y     = (prod_y_r + RND16) >>> 16;
    sm_x_sum = (SW+1)'(smooth_x_r) + fr_x[SW:0];
    sm_y_sum = (SW+1)'(smooth_y_r) + fr_y[SW:0];
  end

  // angle accumulation
  logic signed [MW-1:0]      sc_x, sc_y;
  logic signed [VW-1:0]      yaw_ext, pitch_ext, pitch_sum, pitch_cl;
  logic signed [plc_pkg::SENS_W:0] sens_s;

  always_comb begin
    sens_s    = $signed({1'b0, sens_r});
    sc_x      = (prod_x_r + RNDSH) >>> SH;
    sc_y      = (prod_y_r + RNDSH) >>> SH;
    yaw_ext   = $signed({{(VW - YAW_W){1'b0}}, yaw_r});
    pitch_ext = VW'(pitch_r);
    pitch_sum = pitch_ext - sc_y[VW-1:0];
    if (pitch_sum > PLIM_P) begin
      pitch_cl = PLIM_P;
    end else if (pitch_sum < PLIM_N) begin
      pitch_cl = PLIM_N;
    end else begin
      pitch_cl = pitch_sum;
    end
  end

  // yaw wrap: lift negatives by 16 turns, then strip 8, 4, 2, 1 turns
  logic signed [VW-1:0] mod_k, v_nxt;

  always_comb begin
    case (cmd.wrap_step)
      3'd1:    mod_k = MOD8;
      3'd2:    mod_k = MOD4;
      3'd3:    mod_k = MOD2;
      3'd4:    mod_k = MOD1;
      default: mod_k = MOD16;
    endcase
    if (cmd.wrap_step == '0) begin
      v_nxt = v_r[VW-1] ? (v_r + MOD16) : v_r;
    end else begin
      v_nxt = (v_r >= mod_k) ? (v_r - mod_k) : v_r;
    end
  end

  // state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r   <= -PW'(16);
      last_y_r   <= -PW'(16);
      smooth_x_r <= '0;
      smooth_y_r <= '0;
      yaw_r      <= YAW_RST;
      pitch_r    <= PITCH_RST;
      sens_r     <= plc_pkg::SENS_RST;
    end else begin
      if (cfg_we) begin
        sens_r <= cfg_look_sensitivity;
      end
      if (cmd.classify && !flags.skip) begin
        last_x_r <= px_r;
        last_y_r <= py_r;
      end
      if (cmd.smooth_upd) begin
        smooth_x_r <= sm_x_sum[SW-1:0];
        smooth_y_r <= sm_y_sum[SW-1:0];
      end
      if (cmd.accum) begin
        pitch_r <= pitch_cl[PITCH_W-1:0];
      end
      if (cmd.wrap_last) begin
        yaw_r <= v_nxt[YAW_W-1:0];
      end
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px_r <= in_pointer_x;
      py_r <= in_pointer_y;
      vp_r <= in_in_viewport;
      ui_r <= in_ui_wants_pointer;
    end
    if (cmd.classify) begin
      status_r <= status_nxt;
      tx_r     <= tx_nxt;
      ty_r     <= ty_nxt;
    end
    if (cmd.mul_smooth) begin
      prod_x_r <= diff_x * WEIGHT;
      prod_y_r <= diff_y * WEIGHT;
    end else if (cmd.mul_sens) begin
      prod_x_r <= smooth_x_r * sens_s;
      prod_y_r <= smooth_y_r * sens_s;
    end
    if (cmd.accum) begin
      v_r <= yaw_ext - sc_x[VW-1:0];
    end else if (cmd.wrap) begin
      v_r <= v_nxt;
    end
    if (cmd.out_load) begin
      out_status_r <= status_r;
      out_yaw_r    <= plc_pkg::YAW_OUT_W'(yaw_r);
      out_pitch_r  <= plc_pkg::PITCH_OUT_W'(pitch_r);
      out_sdx_r    <= smooth_x_r;
      out_sdy_r    <= smooth_y_r;
    end
  end

  assign out_status      = out_status_r;
  assign out_yaw_angle   = out_yaw_r;
  assign out_pitch_angle = out_pitch_r;
  assign out_smooth_dx   = out_sdx_r;
  assign out_smooth_dy   = out_sdy_r;

endmodule

// ----- hw/rtl/pointer_look_conditioner.sv -----
// ----------------------------------------------------------------------------
// pointer_look_conditioner
// Turns one pointer position per frame into a smoothed yaw/pitch look angle.
//
//   channel  handshake          payload
//   in       in_valid/in_stall  pointer_x, pointer_y, in_viewport,
//                               ui_wants_pointer
//   out      out_valid/out_stall status, yaw_angle, pitch_angle,
//                               smooth_dx, smooth_dy
//   cfg      cfg_we             look_sensitivity
//
// Skipped, initializing and rejected items go from classify straight to the
// result load; updates pass through classify, a filter multiply and add, a
// sensitivity multiply, accumulate, a 5-step yaw wrap and the result load.
// An item holds the block from acceptance until its result load; the next
// is taken once the result is registered, while that result may still be
// stalled on the output. A stalled result delays the load of the next one.
// Synchronous active-low reset restores the angle state and sensitivity 410.
// ----------------------------------------------------------------------------
module pointer_look_conditioner #(
  parameter int ANGLE_FRAC_BITS = plc_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [plc_pkg::PTR_W-1:0]       in_pointer_x,
  input  logic signed [plc_pkg::PTR_W-1:0]       in_pointer_y,
  input  logic                                   in_in_viewport,
  input  logic                                   in_ui_wants_pointer,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [1:0]                             out_status,
  output logic [plc_pkg::YAW_OUT_W-1:0]          out_yaw_angle,
  output logic signed [plc_pkg::PITCH_OUT_W-1:0] out_pitch_angle,
  output logic signed [plc_pkg::SMOOTH_W-1:0]    out_smooth_dx,
  output logic signed [plc_pkg::SMOOTH_W-1:0]    out_smooth_dy,
  input  logic                                   cfg_we,
  input  logic [plc_pkg::SENS_W-1:0]             cfg_look_sensitivity
);

  plc_pkg::cmd_t          cmd;
  plc_pkg::sample_flags_t flags;

  plc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .flags     (flags),
    .cmd       (cmd)
  );

  plc_dp #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .flags                (flags),
    .in_pointer_x         (in_pointer_x),
    .in_pointer_y         (in_pointer_y),
    .in_in_viewport       (in_in_viewport),
    .in_ui_wants_pointer  (in_ui_wants_pointer),
    .cfg_we               (cfg_we),
    .cfg_look_sensitivity (cfg_look_sensitivity),
    .out_status           (out_status),
    .out_yaw_angle        (out_yaw_angle),
    .out_pitch_angle      (out_pitch_angle),
    .out_smooth_dx        (out_smooth_dx),
    .out_smooth_dy        (out_smooth_dy)
  );

endmodule

// ----- test/pointer_look_conditioner_test.sv -----
// ----------------------------------------------------------------------------
// pointer_look_conditioner_test
// Self-checking bench for the pointer look conditioner. Pointer samples are
// driven with random sender gaps and receiver stalls; a scoreboard predicts
// status, yaw, pitch and smoothed deltas per item and checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pointer_look_conditioner_test;

  localparam int AFB             = plc_pkg::ANGLE_FRAC_BITS_DEF;
  localparam int PITCH_RESET_Q16 = -2311087;
  localparam int DEAD_ZONE_SQ    = 2;
  localparam int SENS_SHIFT      = 16 + plc_pkg::SENS_FRAC_BITS - AFB;
  localparam int PHASES          = 6;
  localparam int PHASE_ITEMS     = 65;
  localparam int STALL_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 20;

  typedef struct packed {
    logic signed [plc_pkg::PTR_W-1:0] px;
    logic signed [plc_pkg::PTR_W-1:0] py;
    logic                             viewport;
    logic                             ui_wants;
  } pointer_item_t;

  typedef struct packed {
    plc_pkg::status_t                       status;
    logic [plc_pkg::YAW_OUT_W-1:0]          yaw;
    logic signed [plc_pkg::PITCH_OUT_W-1:0] pitch;
    logic signed [plc_pkg::SMOOTH_W-1:0]    sdx;
    logic signed [plc_pkg::SMOOTH_W-1:0]    sdy;
  } look_result_t;

  class look_scoreboard;
    int           last_x;
    int           last_y;
    longint       smooth_x;
    longint       smooth_y;
    longint       yaw_acc;
    longint       pitch_acc;
    int           sens;
    look_result_t expected_q[$];
    int           errors;
    int           status_seen[4];

    function new();
      last_x    = -16;
      last_y    = -16;
      smooth_x  = 0;
      smooth_y  = 0;
      yaw_acc   = longint'(225) << AFB;
      pitch_acc = round_shift(longint'(PITCH_RESET_Q16) * (longint'(1) << AFB), 16);
      sens      = int'(plc_pkg::SENS_RST);
      errors    = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // round to nearest, halves toward +inf
    function longint round_shift(longint v, int k);
      return (v + (longint'(1) << (k - 1))) >>> k;
    endfunction

    function longint clamp_to(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function void set_sens(int v);
      sens = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(pointer_item_t it);
      longint       dx;
      longint       dy;
      longint       yaw_mod;
      look_result_t r;
      yaw_mod = longint'(360) << AFB;
      if (!it.viewport && it.ui_wants) begin
        r.status = plc_pkg::ST_SKIPPED;
      end else if (last_x < 0 || last_y < 0) begin
        last_x   = int'(it.px);
        last_y   = int'(it.py);
        r.status = plc_pkg::ST_INIT;
      end else begin
        dx     = longint'(it.px) - last_x;
        dy     = longint'(it.py) - last_y;
        last_x = int'(it.px);
        last_y = int'(it.py);
        if (dx > plc_pkg::JUMP_LIMIT || dx < -plc_pkg::JUMP_LIMIT ||
            dy > plc_pkg::JUMP_LIMIT || dy < -plc_pkg::JUMP_LIMIT) begin
          r.status = plc_pkg::ST_JUMP;
        end else begin
          dx = clamp_to(dx, plc_pkg::DELTA_LIMIT);
          dy = clamp_to(dy, plc_pkg::DELTA_LIMIT);
          if (dx * dx + dy * dy <= DEAD_ZONE_SQ) begin
            dx = 0;
            dy = 0;
          end
          // sixteenths to Q.16 pixels, then first-order low-pass
          smooth_x += round_shift((dx * 4096 - smooth_x) * plc_pkg::SMOOTH_WEIGHT, 16);
          smooth_y += round_shift((dy * 4096 - smooth_y) * plc_pkg::SMOOTH_WEIGHT, 16);
          yaw_acc   -= round_shift(smooth_x * sens, SENS_SHIFT);
          pitch_acc -= round_shift(smooth_y * sens, SENS_SHIFT);
          pitch_acc  = clamp_to(pitch_acc, longint'(89) << AFB);
          yaw_acc    = yaw_acc % yaw_mod;
          if (yaw_acc < 0) yaw_acc += yaw_mod;
          r.status = plc_pkg::ST_UPDATED;
        end
      end
      r.yaw   = yaw_acc[plc_pkg::YAW_OUT_W-1:0];
      r.pitch = pitch_acc[plc_pkg::PITCH_OUT_W-1:0];
      r.sdx   = smooth_x[plc_pkg::SMOOTH_W-1:0];
      r.sdy   = smooth_y[plc_pkg::SMOOTH_W-1:0];
      expected_q.push_back(r);
    endfunction

    function void check_result(look_result_t got);
      look_result_t want;
      status_seen[int'(got.status)]++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0d yaw %0d",
                 $time, got.status, got.yaw);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      end
      if (got.yaw !== want.yaw) begin
        errors++;
        $display("%0t: yaw_angle expected %0d actual %0d", $time, want.yaw, got.yaw);
      end
      if (got.pitch !== want.pitch) begin
        errors++;
        $display("%0t: pitch_angle expected %0d actual %0d", $time, want.pitch, got.pitch);
      end
      if (got.sdx !== want.sdx) begin
        errors++;
        $display("%0t: smooth_dx expected %0d actual %0d", $time, want.sdx, got.sdx);
      end
      if (got.sdy !== want.sdy) begin
        errors++;
        $display("%0t: smooth_dy expected %0d actual %0d", $time, want.sdy, got.sdy);
      end
    endfunction
  endclass

  logic                                   clk = 1'b0;
  logic                                   rst_n;
  logic                                   in_valid;
  logic                                   in_stall;
  logic signed [plc_pkg::PTR_W-1:0]       in_pointer_x;
  logic signed [plc_pkg::PTR_W-1:0]       in_pointer_y;
  logic                                   in_in_viewport;
  logic                                   in_ui_wants_pointer;
  logic                                   out_valid;
  logic                                   out_stall;
  logic [1:0]                             out_status;
  logic [plc_pkg::YAW_OUT_W-1:0]          out_yaw_angle;
  logic signed [plc_pkg::PITCH_OUT_W-1:0] out_pitch_angle;
  logic signed [plc_pkg::SMOOTH_W-1:0]    out_smooth_dx;
  logic signed [plc_pkg::SMOOTH_W-1:0]    out_smooth_dy;
  logic                                   cfg_we;
  logic [plc_pkg::SENS_W-1:0]             cfg_look_sensitivity;

  look_scoreboard sb = new();
  int  items_sent = 0;
  int  idle_cycles = 0;
  int  cur_x = 0;
  int  cur_y = 0;
  bit  tx_burst = 1'b0;
  bit  rx_burst = 1'b0;

  pointer_look_conditioner #(
    .ANGLE_FRAC_BITS(AFB)
  ) uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_pointer_x         (in_pointer_x),
    .in_pointer_y         (in_pointer_y),
    .in_in_viewport       (in_in_viewport),
    .in_ui_wants_pointer  (in_ui_wants_pointer),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_yaw_angle        (out_yaw_angle),
    .out_pitch_angle      (out_pitch_angle),
    .out_smooth_dx        (out_smooth_dx),
    .out_smooth_dy        (out_smooth_dy),
    .cfg_we               (cfg_we),
    .cfg_look_sensitivity (cfg_look_sensitivity)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic pointer_item_t make_item(int x, int y, bit vp, bit ui);
    pointer_item_t it;
    it.px       = x[plc_pkg::PTR_W-1:0];
    it.py       = y[plc_pkg::PTR_W-1:0];
    it.viewport = vp;
    it.ui_wants = ui;
    return it;
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, 81919)) - 16384;
  endfunction

  function automatic int draw_delta(int lo, int hi);
    int mag;
    mag = int'($urandom_range(lo, hi));
    return $urandom_range(0, 1) ? mag : -mag;
  endfunction

  function automatic int clip(int v);
    return v < 0 ? 0 : (v > 65535 ? 65535 : v);
  endfunction

  // mostly plausible pointer motion from the tracked position, some noise
  function automatic pointer_item_t next_item();
    int r;
    int x;
    int y;
    bit vp;
    bit ui;
    r  = $urandom_range(0, 99);
    vp = 1'($urandom_range(0, 1));
    ui = vp ? 1'($urandom_range(0, 1)) : 1'b0;
    x  = cur_x;
    y  = cur_y;
    if (r < 6) return make_item(rand_coord(), rand_coord(), 1'b0, 1'b1);
    if (r < 10) begin
      x  = rand_coord();
      y  = rand_coord();
      vp = 1'($urandom_range(0, 1));
      ui = 1'($urandom_range(0, 1));
    end else if (r < 14) begin
      if ($urandom_range(0, 1)) x = 0 - int'($urandom_range(1, 16384));
      else y = 0 - int'($urandom_range(1, 16384));
    end else if (r < 18) begin
      x = clip(cur_x + draw_delta(8001, 20000));
      y = clip(cur_y + draw_delta(0, 200));
    end else if (r < 26) begin
      x = clip(cur_x + draw_delta(3000, 8000));
      y = clip(cur_y + draw_delta(3000, 8000));
    end else if (r < 34) begin
      x = clip(cur_x + draw_delta(0, 1));
      y = clip(cur_y + draw_delta(0, 1));
    end else begin
      x = clip(cur_x + draw_delta(0, 200));
      y = clip(cur_y + draw_delta(0, 200));
    end
    if (!(!vp && ui) && x >= 0 && y >= 0) begin
      cur_x = x;
      cur_y = y;
    end
    return make_item(x, y, vp, ui);
  endfunction

  task automatic send_item(pointer_item_t it);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 17);
    if ($urandom_range(0, 19) == 0) tx_burst = !tx_burst;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_pointer_x        <= it.px;
    in_pointer_y        <= it.py;
    in_in_viewport      <= it.viewport;
    in_ui_wants_pointer <= it.ui_wants;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    items_sent++;
  endtask

  // only while nothing is in flight
  task automatic write_sensitivity(logic [plc_pkg::SENS_W-1:0] v);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    cfg_we               <= 1'b1;
    cfg_look_sensitivity <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_sens(int'(v));
  endtask

  // result side: random stall per item, then take the next result
  initial begin
    int           n;
    look_result_t got;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      n = rx_burst ? 0 : $urandom_range(0, 17);
      if ($urandom_range(0, 19) == 0) rx_burst = !rx_burst;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      got.status = plc_pkg::status_t'(out_status);
      got.yaw    = out_yaw_angle;
      got.pitch  = out_pitch_angle;
      got.sdx    = out_smooth_dx;
      got.sdy    = out_smooth_dy;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, sb.pending());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int phase;
    in_valid             <= 1'b0;
    in_pointer_x         <= '0;
    in_pointer_y         <= '0;
    in_in_viewport       <= 1'b0;
    in_ui_wants_pointer  <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_look_sensitivity <= plc_pkg::SENS_RST;
    rst_n                <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // ui owns pointer, then first sample only initializes
    send_item(make_item(100, 100, 1'b0, 1'b1));
    send_item(make_item(1000, 1000, 1'b1, 1'b1));
    // dead zone edges: one sixteenth, then dx*dx+dy*dy exactly 2, then 4
    send_item(make_item(1001, 1000, 1'b0, 1'b0));
    send_item(make_item(1002, 1001, 1'b1, 1'b0));
    send_item(make_item(1004, 1001, 1'b1, 1'b1));
    // exactly at the jump limit gets clamped, one past is rejected
    send_item(make_item(9004, 1001, 1'b1, 1'b0));
    send_item(make_item(1003, 1001, 1'b1, 1'b0));
    send_item(make_item(1003, 9002, 1'b1, 1'b0));
    send_item(make_item(1003, 4002, 1'b1, 1'b0));
    send_item(make_item(1003, 3000, 1'b1, 1'b0));
    // negative store forces re-initialization
    send_item(make_item(-16384, 0, 1'b1, 1'b0));
    send_item(make_item(65535, 65535, 1'b1, 1'b0));
    send_item(make_item(62335, 65535, 1'b1, 1'b0));
    send_item(make_item(65535, 62335, 1'b1, 1'b0));
    send_item(make_item(500, -1, 1'b1, 1'b0));
    send_item(make_item(0, 0, 1'b1, 1'b0));
    send_item(make_item(0, 0, 1'b0, 1'b0));
    send_item(make_item(-1, -16384, 1'b0, 1'b1));
    cur_x = 0;
    cur_y = 0;

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       ;
        1:       write_sensitivity('0);
        2:       write_sensitivity('1);
        3:       write_sensitivity(16'd1);
        default: write_sensitivity(plc_pkg::SENS_W'($urandom_range(0, 65535)));
      endcase
      repeat (PHASE_ITEMS) send_item(next_item());
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d pointer items over %0d sensitivity settings",
             items_sent, PHASES);
    $display("results: %0d updated, %0d skipped, %0d initialized, %0d jumps rejected",
             sb.status_seen[plc_pkg::ST_UPDATED], sb.status_seen[plc_pkg::ST_SKIPPED],
             sb.status_seen[plc_pkg::ST_INIT], sb.status_seen[plc_pkg::ST_JUMP]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- pointer_look_conditioner.f -----
hw/rtl/plc_pkg.sv
hw/rtl/plc_ctrl.sv
hw/rtl/plc_dp.sv
hw/rtl/pointer_look_conditioner.sv
test/pointer_look_conditioner_test.sv
